FILE: design/fpwr_pkg.sv
package fpwr_pkg;

	// Pixel formats, as held in the pixel_format register.
	typedef enum logic [1:0] {
		FMT_8  = 2'd0,
		FMT_16 = 2'd1,
		FMT_24 = 2'd2,
		FMT_32 = 2'd3
	} fmt_t;

	// Raster operation codes for 16 bpp. Code 3 behaves as set.
	localparam logic [1:0] OP_SET = 2'd0;
	localparam logic [1:0] OP_XOR = 2'd1;
	localparam logic [1:0] OP_AVG = 2'd2;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 21;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_OP     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RED_MASK     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_MASK   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_MASK    = 3'd5;

	// Register reset values.
	localparam logic [15:0] RED_MASK_RST   = 16'hf800;
	localparam logic [15:0] GREEN_MASK_RST = 16'h07e0;
	localparam logic [15:0] BLUE_MASK_RST  = 16'h001f;

	// Field masks applied after the halving shift in the average operation.
	localparam logic [15:0] GREEN_HALF_MASK = 16'h7fe0;
	localparam logic [15:0] RED_HALF_MASK   = 16'h7800;
	// The fourth byte of a 24 bpp store is always all ones.
	localparam logic [31:0] TOP_BYTE_24 = 32'hff000000;

	// Field widths of the pixel and result beats.
	localparam int unsigned POS_W   = 12;
	localparam int unsigned COLOR_W = 32;
	localparam int unsigned BADDR_W = 20;
	localparam int unsigned NBYTE_W = 3;
	localparam int unsigned STRIDE_W = 21;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_MUL   = 3'd1,
		ST_ADD   = 3'd2,
		ST_READ  = 3'd3,
		ST_WRITE = 3'd4
	} st_t;

	// Command from the sequencer to the frame memory.
	typedef struct packed {
		logic               rd;
		logic               wr;
		logic [NBYTE_W-1:0] nbytes;
	} mem_cmd_t;

	// Number of bytes stored per pixel write.
	function automatic logic [NBYTE_W-1:0] store_bytes(input fmt_t fmt);
		logic [NBYTE_W-1:0] n;
		unique case (fmt)
			FMT_8:   n = 3'd1;
			FMT_16:  n = 3'd2;
			FMT_24:  n = 3'd4;
			FMT_32:  n = 3'd4;
			default: n = 3'd4;
		endcase
		return n;
	endfunction

endpackage

FILE: design/fpwr_ifs.sv
// Pixel write beat: one (x, y, color) triple.
interface fpwr_px_if;
	logic                            valid;
	logic                            ready;
	logic [fpwr_pkg::POS_W-1:0]      pos_x;
	logic [fpwr_pkg::POS_W-1:0]      pos_y;
	logic [fpwr_pkg::COLOR_W-1:0]    color;

	modport src (output valid, output pos_x, output pos_y, output color, input ready);
	modport snk (input valid, input pos_x, input pos_y, input color, output ready);
endinterface

// Result beat: one per pixel write.
interface fpwr_res_if;
	logic                            valid;
	logic                            ready;
	logic [fpwr_pkg::BADDR_W-1:0]    byte_address;
	logic [31:0]                     written_value;
	logic [fpwr_pkg::NBYTE_W-1:0]    bytes_written;
	logic                            out_of_range;

	modport src (output valid, output byte_address, output written_value,
		output bytes_written, output out_of_range, input ready);
	modport snk (input valid, input byte_address, input written_value,
		input bytes_written, input out_of_range, output ready);
endinterface

// Configuration write beat.
interface fpwr_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [fpwr_pkg::CFG_IDX_W-1:0]    index;
	logic [fpwr_pkg::CFG_DATA_W-1:0]   data;

	modport src (output valid, output index, output data, input ready);
	modport snk (input valid, input index, input data, output ready);
endinterface

FILE: design/framebuffer_pixel_write_rop_top.sv
// The sequencer handles one pixel at a time through multiply, address check, optional
// old-pixel read (only for an in-range 16 bpp pixel), and write-back, and waits there
// while the previous result is held; a new pixel is taken only once it is back in idle.
// Reset: registers take their reset values and a clearing pass zeroes the frame memory;
// pixels wait, configuration does not.
module framebuffer_pixel_write_rop_top #(
	parameter int unsigned FB_BYTES = 1048576
) (
	input  logic            clk,
	input  logic            arst_n,
	fpwr_px_if.snk          px,
	fpwr_res_if.src         res,
	fpwr_cfg_if.snk         cfg
);

	import fpwr_pkg::*;

	localparam int unsigned AW     = $clog2(FB_BYTES);
	localparam int unsigned XOFF_W = POS_W + 2;
	localparam int unsigned PROD_W = POS_W + STRIDE_W;
	localparam int unsigned SUM_W  = PROD_W + 1;

	// Configuration registers.
	fmt_t                pixel_format_q;
	logic [1:0]          write_op_q;
	logic [STRIDE_W-1:0] line_stride_q;
	logic [15:0]         red_mask_q;
	logic [15:0]         green_mask_q;
	logic [15:0]         blue_mask_q;

	// Per-pixel working registers.
	st_t                 state_q;
	st_t                 state_d;
	logic [POS_W-1:0]    x_q;
	logic [POS_W-1:0]    y_q;
	logic [COLOR_W-1:0]  color_q;
	logic [PROD_W-1:0]   prod_q;
	logic [XOFF_W-1:0]   xoff_q;
	logic [AW-1:0]       addr_q;
	logic [BADDR_W-1:0]  baddr_q;
	logic                oor_q;

	// Output register.
	logic                res_vld_q;
	logic [BADDR_W-1:0]  res_addr_q;
	logic [31:0]         res_value_q;
	logic [NBYTE_W-1:0]  res_nbytes_q;
	logic                res_oor_q;

	logic [SUM_W-1:0]    addr_sum;
	logic [SUM_W-1:0]    addr_lim;
	logic                oor_d;
	logic [XOFF_W-1:0]   xoff_d;
	logic [NBYTE_W-1:0]  nbytes;
	logic                px_rdy;
	logic                load;
	logic                clr_busy;
	mem_cmd_t            cmd;
	logic [15:0]         old_pix;
	logic [31:0]         value;

	assign nbytes = store_bytes(pixel_format_q);

	// Configuration writes; taken in any cycle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= FMT_32;
			write_op_q     <= OP_SET;
			line_stride_q  <= '0;
			red_mask_q     <= RED_MASK_RST;
			green_mask_q   <= GREEN_MASK_RST;
			blue_mask_q    <= BLUE_MASK_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PIXEL_FORMAT: pixel_format_q <= fmt_t'(cfg.data[1:0]);
				REG_WRITE_OP:     write_op_q     <= cfg.data[1:0];
				REG_LINE_STRIDE:  line_stride_q  <= cfg.data;
				REG_RED_MASK:     red_mask_q     <= cfg.data[15:0];
				REG_GREEN_MASK:   green_mask_q   <= cfg.data[15:0];
				REG_BLUE_MASK:    blue_mask_q    <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	// Column offset in bytes: x times 1, 2, 3 or 4.
	always_comb begin
		unique case (pixel_format_q)
			FMT_8:   xoff_d = XOFF_W'(x_q);
			FMT_16:  xoff_d = XOFF_W'(x_q) << 1;
			FMT_24:  xoff_d = XOFF_W'(x_q) + (XOFF_W'(x_q) << 1);
			FMT_32:  xoff_d = XOFF_W'(x_q) << 2;
			default: xoff_d = XOFF_W'(x_q) << 2;
		endcase
	end

	// Address and bounds check: the last byte must lie below FB_BYTES.
	assign addr_sum = SUM_W'(prod_q) + SUM_W'(xoff_q);
	assign addr_lim = SUM_W'(FB_BYTES) - SUM_W'(nbytes);
	assign oor_d    = addr_sum > addr_lim;

	// Sequencer: next state and per-state controls.
	always_comb begin
		state_d    = state_q;
		px_rdy     = 1'b0;
		load       = 1'b0;
		cmd        = '0;
		cmd.nbytes = nbytes;
		unique case (state_q)
			ST_IDLE: begin
				px_rdy = !clr_busy;
				if (px.valid && !clr_busy) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				if (!oor_d && pixel_format_q == FMT_16) begin
					state_d = ST_READ;
				end else begin
					state_d = ST_WRITE;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (!res_vld_q || res.ready) begin
					load    = 1'b1;
					cmd.wr  = !oor_q;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign px.ready = px_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working registers of the pixel in flight.
	always_ff @(posedge clk) begin
		if (px.valid && px_rdy) begin
			x_q     <= px.pos_x;
			y_q     <= px.pos_y;
			color_q <= px.color;
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(y_q) * PROD_W'(line_stride_q);
			xoff_q <= xoff_d;
		end
		if (state_q == ST_ADD) begin
			addr_q  <= addr_sum[AW-1:0];
			baddr_q <= addr_sum[BADDR_W-1:0];
			oor_q   <= oor_d;
		end
	end

	fpwr_mem #(
		.FB_BYTES (FB_BYTES)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.addr     (addr_q),
		.wdata    (value),
		.rdata    (old_pix),
		.clr_busy (clr_busy)
	);

	fpwr_rop u_rop (
		.fmt        (pixel_format_q),
		.op         (write_op_q),
		.red_mask   (red_mask_q),
		.green_mask (green_mask_q),
		.blue_mask  (blue_mask_q),
		.color      (color_q),
		.old_pix    (old_pix),
		.value      (value)
	);

	// Output register; a dropped write reports zeros and the range flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (load) begin
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_addr_q   <= oor_q ? '0 : baddr_q;
			res_value_q  <= oor_q ? '0 : value;
			res_nbytes_q <= oor_q ? '0 : nbytes;
			res_oor_q    <= oor_q;
		end
	end

	assign res.valid         = res_vld_q;
	assign res.byte_address  = res_addr_q;
	assign res.written_value = res_value_q;
	assign res.bytes_written = res_nbytes_q;
	assign res.out_of_range  = res_oor_q;

`ifndef SYNTHESIS
	// A taken pixel starts the address multiply in the next cycle.
	a_accept_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		px.valid && px.ready |=> state_q == ST_MUL)
		else $error("pixel beat taken but sequencer did not start");

	// Outside the clearing pass, the frame memory is written only for an in-range pixel at write-back.
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> state_q == ST_WRITE && !oor_q && !clr_busy)
		else $error("frame memory written outside an in-range write-back");

	// The old pixel is read only at 16 bpp.
	a_read_16bpp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> pixel_format_q == FMT_16 && !oor_q)
		else $error("old pixel read outside 16 bpp");

	// A result appears only after a write-back cycle.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_vld_q) |-> $past(state_q == ST_WRITE))
		else $error("result raised without a write-back");

	// A dropped write reports no address and no bytes.
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && res_oor_q |-> res_nbytes_q == '0 && res_addr_q == '0)
		else $error("dropped write reports stored bytes");

	// Pixels are not taken during the clearing pass.
	a_no_px_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !px.ready)
		else $error("pixel beat accepted during memory clear");
`endif

endmodule

FILE: design/fpwr_ram.sv
module fpwr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port, registered read; read data holds until the next read.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

FILE: design/fpwr_mem.sv
module fpwr_mem #(
	parameter int unsigned FB_BYTES = 1048576
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fpwr_pkg::mem_cmd_t            cmd,
	input  logic [$clog2(FB_BYTES)-1:0]   addr,
	input  logic [31:0]                   wdata,
	output logic [15:0]                   rdata,
	output logic                          clr_busy
);

	import fpwr_pkg::*;

	localparam int unsigned DEPTH = (FB_BYTES + 3) / 4;
	localparam int unsigned RW    = $clog2(DEPTH);

	logic [RW-1:0] clr_cnt_q;
	logic          clr_busy_q;
	logic [1:0]    off_q;
	logic [7:0]    lane_rd [4];
	logic [RW-1:0] base_row;

	assign base_row = RW'(addr >> 2);
	assign clr_busy = clr_busy_q;

	// Clearing pass after reset: one row of four bytes per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			if (clr_cnt_q == RW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// Byte offset of a read, kept to steer the lanes when the data returns.
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			off_q <= addr[1:0];
		end
	end

	// Four byte lanes; byte i of an access lands in lane (addr + i) mod 4.
	for (genvar k = 0; k < 4; k++) begin : g_lane
		logic [1:0]    rel;
		logic [RW-1:0] row;
		logic          hit;
		logic          en;
		logic          we;
		logic [RW-1:0] ram_addr;
		logic [7:0]    ram_wdata;
		logic [31:0]   shifted;

		always_comb begin
			rel       = 2'(k) - addr[1:0];
			row       = base_row + RW'(2'(k) < addr[1:0]);
			hit       = {1'b0, rel} < cmd.nbytes;
			shifted   = wdata >> {rel, 3'b000};
			we        = clr_busy_q || (cmd.wr && hit);
			en        = we || (cmd.rd && !clr_busy_q);
			ram_addr  = clr_busy_q ? clr_cnt_q : row;
			ram_wdata = clr_busy_q ? 8'h00 : shifted[7:0];
		end

		fpwr_ram #(
			.WIDTH (8),
			.DEPTH (DEPTH)
		) u_ram (
			.clk   (clk),
			.en    (en),
			.we    (we),
			.addr  (ram_addr),
			.wdata (ram_wdata),
			.rdata (lane_rd[k])
		);
	end

	// Old 16-bit pixel, little-endian, from the two lanes it occupies.
	assign rdata = {lane_rd[off_q + 2'd1], lane_rd[off_q]};

endmodule

FILE: design/fpwr_rop.sv
module fpwr_rop (
	input  fpwr_pkg::fmt_t  fmt,
	input  logic [1:0]      op,
	input  logic [15:0]     red_mask,
	input  logic [15:0]     green_mask,
	input  logic [15:0]     blue_mask,
	input  logic [31:0]     color,
	input  logic [15:0]     old_pix,
	output logic [31:0]     value
);

	import fpwr_pkg::*;

	logic [15:0] nw;
	logic [15:0] avg_g;
	logic [15:0] avg_b;
	logic [15:0] avg_r;
	logic [15:0] pix16;

	assign nw = color[15:0];

	// Field-wise average under the channel masks; carries past a mask are dropped.
	always_comb begin
		avg_g = ((((green_mask & old_pix) >> 1) & GREEN_HALF_MASK) +
			(((green_mask & nw) >> 1) & GREEN_HALF_MASK)) & green_mask;
		avg_b = (((blue_mask & nw) >> 1) + ((blue_mask & old_pix) >> 1)) & blue_mask;
		avg_r = (((nw >> 1) & RED_HALF_MASK) + ((old_pix >> 1) & RED_HALF_MASK)) & red_mask;
	end

	// 16 bpp raster operation.
	always_comb begin
		priority if (op == OP_XOR) begin
			pix16 = old_pix ^ nw;
		end else if (op == OP_AVG) begin
			pix16 = avg_g | avg_b | avg_r;
		end else begin
			pix16 = nw;
		end
	end

	// Stored value by format.
	always_comb begin
		unique case (fmt)
			FMT_8:   value = {24'h000000, color[7:0]};
			FMT_16:  value = {16'h0000, pix16};
			FMT_24:  value = color | TOP_BYTE_24;
			FMT_32:  value = color;
			default: value = color;
		endcase
	end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import fpwr_pkg::*;

	localparam int unsigned FB_BYTES      = 1048576;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned LIMIT_CYCLES  = 262144 + 400000;
	localparam int unsigned RAND_PHASES   = 18;
	localparam int unsigned PHASE_ITEMS   = 25;

	// One result beat as the block should produce it.
	typedef struct {
		logic [BADDR_W-1:0] byte_address;
		logic [31:0]        written_value;
		logic [NBYTE_W-1:0] bytes_written;
		logic               out_of_range;
	} pixel_result_t;

	// Shadow of the frame memory and registers, with the queue of results still owed.
	class fb_write_scoreboard;
		fmt_t          fmt;
		logic [1:0]    op;
		logic [20:0]   stride;
		logic [15:0]   rmask;
		logic [15:0]   gmask;
		logic [15:0]   bmask;
		// Sparse shadow: a byte that was never stored reads as zero, as after the clear.
		byte unsigned  fb_shadow [int unsigned];
		pixel_result_t pending_q [$];
		int unsigned   errors;
		int unsigned   pixels;
		int unsigned   results;
		int unsigned   drops;

		function new();
			fmt    = FMT_32;
			op     = OP_SET;
			stride = '0;
			rmask  = RED_MASK_RST;
			gmask  = GREEN_MASK_RST;
			bmask  = BLUE_MASK_RST;
			errors = 0;
			pixels = 0;
			results = 0;
			drops  = 0;
		endfunction

		// Only the low bits that fit each register are kept.
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PIXEL_FORMAT: fmt = fmt_t'(data[1:0]);
				REG_WRITE_OP:     op = data[1:0];
				REG_LINE_STRIDE:  stride = data[20:0];
				REG_RED_MASK:     rmask = data[15:0];
				REG_GREEN_MASK:   gmask = data[15:0];
				REG_BLUE_MASK:    bmask = data[15:0];
				default: ;
			endcase
		endfunction

		function logic [7:0] rd_byte(int unsigned a);
			return fb_shadow.exists(a) ? fb_shadow[a] : 8'h00;
		endfunction

		// Field-wise halving average of two 16-bit pixels.
		function logic [15:0] blend16(logic [15:0] old, logic [15:0] nw);
			logic [15:0] g;
			logic [15:0] b;
			logic [15:0] r;
			g = ((((gmask & old) >> 1) & GREEN_HALF_MASK) +
				(((gmask & nw) >> 1) & GREEN_HALF_MASK)) & gmask;
			b = (((bmask & nw) >> 1) + ((bmask & old) >> 1)) & bmask;
			r = (((nw >> 1) & RED_HALF_MASK) + ((old >> 1) & RED_HALF_MASK)) & rmask;
			return g | b | r;
		endfunction

		// Work out the store caused by an accepted pixel beat and queue its result.
		function void note_pixel(logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic [31:0] color);
			longint unsigned lx;
			longint unsigned ly;
			longint unsigned ls;
			longint unsigned step;
			longint unsigned nb;
			longint unsigned addr;
			logic [31:0]     val;
			logic [15:0]     old;
			pixel_result_t   r;
			lx = x;
			ly = y;
			ls = stride;
			case (fmt)
				FMT_8: begin
					step = 1;
					nb = 1;
				end
				FMT_16: begin
					step = 2;
					nb = 2;
				end
				FMT_24: begin
					step = 3;
					nb = 4;
				end
				default: begin
					step = 4;
					nb = 4;
				end
			endcase
			addr = lx * step + ly * ls;
			pixels++;
			if (addr + nb > FB_BYTES) begin
				r = '{byte_address: '0, written_value: '0, bytes_written: '0, out_of_range: 1'b1};
				drops++;
			end else begin
				case (fmt)
					FMT_8:  val = {24'h0, color[7:0]};
					FMT_16: begin
						old = {rd_byte(int'(addr) + 1), rd_byte(int'(addr))};
						case (op)
							OP_XOR:  val = {16'h0, old ^ color[15:0]};
							OP_AVG:  val = {16'h0, blend16(old, color[15:0])};
							default: val = {16'h0, color[15:0]};
						endcase
					end
					FMT_24: val = color | TOP_BYTE_24;
					default: val = color;
				endcase
				for (int i = 0; i < int'(nb); i++)
					fb_shadow[int'(addr) + i] = val[8*i +: 8];
				r = '{byte_address: addr[BADDR_W-1:0], written_value: val,
					bytes_written: nb[NBYTE_W-1:0], out_of_range: 1'b0};
			end
			pending_q.push_back(r);
		endfunction

		// Compare one accepted result beat with the oldest result owed.
		function void check_result(logic [BADDR_W-1:0] a, logic [31:0] v,
				logic [NBYTE_W-1:0] n, logic oor);
			pixel_result_t e;
			results++;
			if (pending_q.size() == 0) begin
				$error("result beat with no pixel outstanding: addr %h value %h", a, v);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (a !== e.byte_address) begin
				$error("byte_address: expected %h, got %h", e.byte_address, a);
				errors++;
			end
			if (v !== e.written_value) begin
				$error("written_value: expected %h, got %h", e.written_value, v);
				errors++;
			end
			if (n !== e.bytes_written) begin
				$error("bytes_written: expected %0d, got %0d", e.bytes_written, n);
				errors++;
			end
			if (oor !== e.out_of_range) begin
				$error("out_of_range: expected %b, got %b", e.out_of_range, oor);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	fpwr_px_if  px_bus ();
	fpwr_res_if res_bus ();
	fpwr_cfg_if cfg_bus ();

	framebuffer_pixel_write_rop_top #(
		.FB_BYTES(FB_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.px(px_bus),
		.res(res_bus),
		.cfg(cfg_bus)
	);

	fb_write_scoreboard sb;
	int unsigned src_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned hold_left = 0;
	int unsigned cycle_count = 0;
	int unsigned cfg_writes = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Give up if the run hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, sb.pending_q.size());
			$display("FAIL framebuffer_pixel_write_rop_top");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off counted down here.
	initial begin
		res_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				res_bus.ready = 1'b0;
				hold_left--;
			end else begin
				res_bus.ready = ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// Observe accepted beats on all three channels.
	always @(posedge clk) begin
		if (arst_n && px_bus.valid && px_bus.ready)
			sb.note_pixel(px_bus.pos_x, px_bus.pos_y, px_bus.color);
		if (arst_n && cfg_bus.valid && cfg_bus.ready) begin
			sb.write_reg(cfg_bus.index, cfg_bus.data);
			cfg_writes++;
		end
		if (arst_n && res_bus.valid === 1'b1 && res_bus.ready)
			sb.check_result(res_bus.byte_address, res_bus.written_value,
				res_bus.bytes_written, res_bus.out_of_range);
	end

	// Offer one pixel beat after a random gap; returns at the falling edge after it is taken.
	task automatic send_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
			input logic [31:0] c);
		while ($urandom_range(99) < src_idle_pct) begin
			px_bus.valid = 1'b0;
			@(negedge clk);
		end
		px_bus.pos_x = x;
		px_bus.pos_y = y;
		px_bus.color = c;
		px_bus.valid = 1'b1;
		@(posedge clk);
		while (!px_bus.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stop offering pixels and wait until every owed result is back and the block is quiet.
	task automatic drain_results();
		px_bus.valid = 1'b0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One register write beat; valid is left high for a following write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_bus.index = idx;
		cfg_bus.data  = data;
		cfg_bus.valid = 1'b1;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic apply_cfg(input logic [20:0] f, input logic [20:0] o, input logic [20:0] s,
			input logic [20:0] rm, input logic [20:0] gm, input logic [20:0] bm);
		drain_results();
		write_reg(REG_PIXEL_FORMAT, f);
		write_reg(REG_WRITE_OP, o);
		write_reg(REG_LINE_STRIDE, s);
		write_reg(REG_RED_MASK, rm);
		write_reg(REG_GREEN_MASK, gm);
		write_reg(REG_BLUE_MASK, bm);
		cfg_bus.valid = 1'b0;
	endtask

	initial begin
		logic [20:0]  r_fmt;
		logic [20:0]  r_op;
		logic [20:0]  r_stride;
		logic [20:0]  r_mask [3];
		int unsigned  base_x;
		int unsigned  base_y;
		int unsigned  lim;
		logic [11:0]  x;
		logic [11:0]  y;

		sb = new();
		arst_n = 1'b0;
		px_bus.valid = 1'b0;
		px_bus.pos_x = '0;
		px_bus.pos_y = '0;
		px_bus.color = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset configuration is 32 bpp with zero stride, so rows alias.
		send_pixel(12'd0, 12'd0, 32'hffffffff);
		send_pixel(12'd4095, 12'd4095, 32'h00000000);
		send_pixel(12'd4095, 12'd0, 32'ha5a55a5a);

		// 8 bpp: the very last byte fits, one past it is dropped.
		apply_cfg(FMT_8, OP_SET, 21'd256, RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST);
		send_pixel(12'd255, 12'd4095, 32'h123456ff);
		send_pixel(12'd256, 12'd4095, 32'hffffffff);
		send_pixel(12'd4095, 12'd4095, 32'h00000000);

		// 16 bpp: set, xor twice and average on one pixel, then two averages on the next one and the unused code as set.
		apply_cfg(FMT_16, OP_SET, 21'd2048, RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST);
		send_pixel(12'd10, 12'd3, 32'h0000f81f);
		apply_cfg(FMT_16, OP_XOR, 21'd2048, RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST);
		send_pixel(12'd10, 12'd3, 32'hffff07e0);
		send_pixel(12'd10, 12'd3, 32'h0000ffff);
		apply_cfg(FMT_16, OP_AVG, 21'd2048, RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST);
		send_pixel(12'd10, 12'd3, 32'h1234ffff);
		send_pixel(12'd11, 12'd3, 32'h00000000);
		send_pixel(12'd11, 12'd3, 32'h0000ffff);
		apply_cfg(FMT_16, 21'd3, 21'd2048, RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST);
		send_pixel(12'd10, 12'd3, 32'hbeef0000);

		// Average under all-ones and all-zero masks, then the 16 bpp memory edge.
		apply_cfg(FMT_16, OP_AVG, 21'd2048, 21'hffff, 21'hffff, 21'hffff);
		send_pixel(12'd12, 12'd3, 32'h0000ffff);
		send_pixel(12'd12, 12'd3, 32'h00005555);
		apply_cfg(FMT_16, OP_AVG, 21'd2048, 21'h0, 21'h0, 21'h0);
		send_pixel(12'd12, 12'd3, 32'h0000aaaa);
		send_pixel(12'd1023, 12'd511, 32'h00001234);
		send_pixel(12'd1024, 12'd511, 32'h00004321);

		// 24 bpp: top byte forced, the spill byte overwritten, and a drop where the pixel
		// would pass the end. The write op is ignored here.
		apply_cfg(FMT_24, OP_XOR, 21'd4096, RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST);
		send_pixel(12'd0, 12'd0, 32'h00abcdef);
		send_pixel(12'd1, 12'd0, 32'h11223344);
		send_pixel(12'd1364, 12'd255, 32'h00fedcba);
		send_pixel(12'd1365, 12'd255, 32'h00777777);

		// Register data wider than the register, writes to unused indexes, largest stride.
		drain_results();
		write_reg(REG_PIXEL_FORMAT, 21'h1ffff8);
		write_reg(REG_WRITE_OP, 21'h1ffff5);
		write_reg(REG_LINE_STRIDE, 21'd1048576);
		write_reg(REG_RED_MASK, 21'h1ff800);
		write_reg(REG_GREEN_MASK, 21'h1f07e0);
		write_reg(REG_BLUE_MASK, 21'h1f001f);
		write_reg(3'd6, 21'h1fffff);
		write_reg(3'd7, 21'h0aaaaa);
		cfg_bus.valid = 1'b0;
		send_pixel(12'd0, 12'd1, 32'h000000ab);
		send_pixel(12'd4095, 12'd0, 32'hffffffff);
		apply_cfg(FMT_32, OP_SET, 21'h1fffff, RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST);
		send_pixel(12'd0, 12'd0, 32'h5a5aa5a5);
		send_pixel(12'd0, 12'd1, 32'h01020304);

		// Random phases: a fresh configuration and idle pattern each, pixels mostly in a
		// small window so read-modify-write hits recently written pixels.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			r_fmt = 21'($urandom_range(3));
			r_op  = 21'($urandom_range(3));
			case ($urandom_range(9))
				0: r_stride = 21'd0;
				1: r_stride = 21'd1048576;
				2: r_stride = 21'h1fffff;
				3: r_stride = 21'($urandom);
				default: r_stride = 21'($urandom_range(4096, 1));
			endcase
			for (int k = 0; k < 3; k++) begin
				case ($urandom_range(5))
					0: r_mask[k] = 21'h0;
					1: r_mask[k] = 21'hffff;
					2, 3: r_mask[k] = 21'($urandom);
					default: r_mask[k] = 21'((k == 0) ? RED_MASK_RST :
						((k == 1) ? GREEN_MASK_RST : BLUE_MASK_RST));
				endcase
			end
			apply_cfg(r_fmt, r_op, r_stride, r_mask[0], r_mask[1], r_mask[2]);

			case (ph % 4)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 53;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 53;
				end
				default: begin
					src_idle_pct = 12;
					sink_stall_pct = 12;
				end
			endcase
			// Once, the receiver holds off while pixels keep coming so the input backs up.
			if (ph == 4)
				hold_left = 600;

			base_x = $urandom_range(4088);
			if (r_stride == 0) begin
				base_y = $urandom_range(4092);
			end else begin
				lim = (FB_BYTES - 16384) / r_stride;
				base_y = $urandom_range((lim > 4092) ? 4092 : lim);
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(99) < 85) begin
					x = 12'(base_x + $urandom_range(7));
					y = 12'(base_y + $urandom_range(3));
				end else begin
					x = 12'($urandom);
					y = 12'($urandom);
				end
				send_pixel(x, y, $urandom);
			end
		end

		drain_results();
		$display("Covered %0d pixel writes in all formats and raster ops over %0d register writes.",
			sb.pixels, cfg_writes);
		$display("Checked %0d result beats, %0d of them dropped past the end of memory, %0d mismatches.",
			sb.results, sb.drops, sb.errors);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("PASS framebuffer_pixel_write_rop_top");
		end else begin
			$display("FAIL framebuffer_pixel_write_rop_top");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/fpwr_pkg.sv
design/fpwr_ifs.sv
design/fpwr_ram.sv
design/fpwr_mem.sv
design/fpwr_rop.sv
design/framebuffer_pixel_write_rop_top.sv
test/testbench.sv
